[src/rwsp_pkg.sv]
// Package with the types, codes and tags shared by the WAV stream parser modules.
package rwsp_pkg;

  localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_CHDR = 3'd1,
    PH_FMT  = 3'd2,
    PH_DATA = 3'd3,
    PH_SKIP = 3'd4,
    PH_PAD  = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_FMT   = 2'd1,
    CK_DATA  = 2'd2
  } chunk_kind_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_RATE   = 2'd1,
    KIND_OK     = 2'd2,
    KIND_FAIL   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_HEADER    = 2'd0,
    ERR_FMT_SMALL = 2'd1,
    ERR_NO_FMT    = 2'd2,
    ERR_NO_DATA   = 2'd3
  } err_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [1:0]  error_code;
    logic        last_in_run;
  } result_t;

  // Results caused by one byte: count (0 to 2) and the entries in order.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[src/rwsp_parser.sv]
// Parser state and the per-byte decision logic for the RIFF/WAVE byte stream.
module rwsp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           eof_i,
  output rwsp_pkg::push_t push_o
);
  import rwsp_pkg::*;

  phase_e      phase_q, phase_d;
  chunk_kind_e kind_q, kind_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] gather_q, gather_d;
  logic [31:0] len_q, len_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic [7:0]  held_q, held_d;
  logic        failed_q, failed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR;
      kind_q      <= CK_OTHER;
      cnt_q       <= '0;
      gather_q    <= '0;
      len_q       <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      held_q      <= '0;
      failed_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      gather_q    <= gather_d;
      len_q       <= len_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      held_q      <= held_d;
      failed_q    <= failed_d;
    end
  end

  always_comb begin
    logic [31:0] pos_inc;
    logic        body_last;
    logic        main_vld;
    result_t     main_r;
    logic        fin_vld;
    result_t     fin_r;

    pos_inc     = cnt_q + 32'd1;
    body_last   = (pos_inc == len_q);
    phase_d     = phase_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    gather_d    = {byte_i, gather_q[31:8]};
    len_d       = len_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    held_d      = held_q;
    failed_d    = failed_q;
    main_vld    = 1'b0;
    main_r      = '0;
    fin_vld     = 1'b0;
    fin_r       = '0;

    case (phase_q)
      PH_HDR: begin
        if (cnt_q == 32'd3 && gather_d != TAG_RIFF) begin
          failed_d = 1'b1;
        end
        if (cnt_q == 32'd11) begin
          if (failed_q || gather_d != TAG_WAVE) begin
            failed_d          = 1'b1;
            main_vld          = 1'b1;
            main_r.kind       = KIND_FAIL;
            main_r.error_code = ERR_HEADER;
            phase_d           = PH_DONE;
          end else begin
            phase_d = PH_CHDR;
            cnt_d   = '0;
          end
        end else begin
          cnt_d = pos_inc;
        end
      end
      PH_CHDR: begin
        if (cnt_q == 32'd3) begin
          if (gather_d == TAG_FMT) begin
            kind_d = CK_FMT;
          end else if (gather_d == TAG_DATA) begin
            kind_d = CK_DATA;
          end else begin
            kind_d = CK_OTHER;
          end
        end
        if (cnt_q == 32'd7) begin
          len_d = gather_d;
          cnt_d = '0;
          if (kind_q == CK_FMT && gather_d < FMT_MIN_SIZE) begin
            main_vld          = 1'b1;
            main_r.kind       = KIND_FAIL;
            main_r.error_code = ERR_FMT_SMALL;
            phase_d           = PH_DONE;
          end else begin
            if (kind_q == CK_DATA) begin
              data_seen_d = 1'b1;
            end
            if (gather_d == '0) begin
              phase_d = PH_CHDR;
            end else if (kind_q == CK_FMT) begin
              phase_d = PH_FMT;
            end else if (kind_q == CK_DATA) begin
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end else begin
          cnt_d = pos_inc;
        end
      end
      PH_FMT, PH_DATA, PH_SKIP: begin
        if (phase_q == PH_FMT && cnt_q == 32'd7) begin
          main_vld     = 1'b1;
          main_r.kind  = KIND_RATE;
          main_r.value = gather_d;
          fmt_seen_d   = 1'b1;
        end
        if (phase_q == PH_DATA) begin
          if (!cnt_q[0]) begin
            held_d = byte_i;
          end else begin
            main_vld     = 1'b1;
            main_r.kind  = KIND_SAMPLE;
            main_r.value = {16'd0, byte_i, held_q};
          end
        end
        if (body_last) begin
          phase_d = len_q[0] ? PH_PAD : PH_CHDR;
          cnt_d   = '0;
        end else begin
          cnt_d = pos_inc;
        end
      end
      PH_PAD: begin
        phase_d = PH_CHDR;
        cnt_d   = '0;
      end
      default: begin
        gather_d = gather_q;
      end
    endcase

    if (phase_q != PH_DONE && eof_i && phase_d != PH_DONE) begin
      fin_vld = 1'b1;
      if (phase_d == PH_HDR) begin
        fin_r.kind       = KIND_FAIL;
        fin_r.error_code = ERR_HEADER;
      end else if (!fmt_seen_d) begin
        fin_r.kind       = KIND_FAIL;
        fin_r.error_code = ERR_NO_FMT;
      end else if (!data_seen_d) begin
        fin_r.kind       = KIND_FAIL;
        fin_r.error_code = ERR_NO_DATA;
      end else begin
        fin_r.kind = KIND_OK;
      end
      phase_d = PH_DONE;
    end

    push_o = '0;
    if (step_i) begin
      if (main_vld) begin
        push_o.r0 = main_r;
        push_o.r1 = fin_r;
        push_o.r0.last_in_run = !fin_vld;
        push_o.r1.last_in_run = fin_vld;
        push_o.n  = fin_vld ? 2'd2 : 2'd1;
      end else if (fin_vld) begin
        push_o.r0 = fin_r;
        push_o.r0.last_in_run = 1'b1;
        push_o.n  = 2'd1;
      end
    end
  end

endmodule

[src/rwsp_out_queue.sv]
// Four-entry result queue: up to two results a cycle, one out when not stalled.
module rwsp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rwsp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rwsp_pkg::result_t head_o
);
  import rwsp_pkg::*;

  result_t               entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]   count_q, count_d;
  logic                  pop;

  assign out_valid_o = (count_q != '0);
  assign head_o      = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= QUEUE_CW'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QUEUE_AW'(push_i.n);
    rd_ptr_d = rd_ptr_q + QUEUE_AW'(pop);
    count_d  = count_q + QUEUE_CW'(push_i.n) - QUEUE_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      entry_q[wr_ptr_q + QUEUE_AW'(1)] <= push_i.r1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("Results were pushed without room for two entries.");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd2 |-> push_i.r1.last_in_run && !push_i.r0.last_in_run)
    else $error("A result pair does not end its run on the second entry.");

  a_pop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.n == 2'd0 |=> count_q == $past(count_q) - QUEUE_CW'(1))
    else $error("Result queue count did not drop after a transaction.");
`endif

endmodule

[src/riff_wave_stream_parser_top.sv]
// Top level of the streaming RIFF/WAVE 16-bit PCM parser.
// The block takes one file byte per cycle unless stalled: a byte is held in an input
// register while the parser updates its state, and its results (a sample, the sample
// rate, or a final ok or failed report, at most two for the last byte) go into a
// four-entry result queue that drives the output channel. Input stall rises only
// while the queue holds more than two results, so with a free-running output side
// the sustained rate is one byte per cycle. After the final report every later byte
// is taken and dropped until reset.
module riff_wave_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] value_o,
  output logic [1:0]  error_code_o,
  output logic        last_in_run_o
);
  import rwsp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eof_q;
  logic       room;
  logic       step;
  logic       accept;
  push_t      push;
  result_t    head;

  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
      in_eof_q  <= end_of_file_i;
    end
  end

  rwsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eof_i  (in_eof_q),
    .push_o (push)
  );

  rwsp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign value_o       = head.value;
  assign error_code_o  = head.error_code;
  assign last_in_run_o = head.last_in_run;

`ifndef SYNTHESIS
  a_step_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd0 |-> in_valid_q && room)
    else $error("Results appeared without a held input byte.");

  a_held_byte_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !room |=> in_valid_q && $stable(in_byte_q) && $stable(in_eof_q))
    else $error("A held input byte was lost while the queue was full.");

  a_result_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> push.n == 2'd0)
    else $error("The parser produced results with no byte to work on.");
`endif

endmodule
